/* hdl/vsbi_pkg.sv */
// Shared constants, codes and types of the volatility surface lookup.
`default_nettype none

package vsbi_pkg;

   // Grid sizes; the node and grid indexes of the input word are four bits wide.
   localparam int MAX_STRIKES  = 16;
   localparam int MAX_EXPIRIES = 16;
   localparam int K_IDX_W      = $clog2(MAX_STRIKES);
   localparam int T_IDX_W      = $clog2(MAX_EXPIRIES);
   localparam int GRID_DEPTH   = MAX_STRIKES * MAX_EXPIRIES;
   localparam int GRID_ADDR_W  = K_IDX_W + T_IDX_W;

   // Field widths.
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;
   localparam int CSR_IDX_W = 2;

   // Coordinates are signed: log2 with 24 fraction bits, or a 32-bit root.
   localparam int FRAC_W  = 24;
   localparam int COORD_W = 34;

   // Weights are Q0.16 with one more bit to hold exactly one.
   localparam int WGT_W = 17;
   localparam logic [WGT_W-1:0] WONE = 17'd65536;

   // Blend datapath widths.
   localparam int ACC_W  = 64;
   localparam int ROW_W  = 48;

   typedef enum logic [1:0] {
      ACT_STRIKE = 2'd0,
      ACT_EXPIRY = 2'd1,
      ACT_VOL    = 2'd2,
      ACT_QUERY  = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPOT_PRICE   = 2'd0,
      CSR_STRIKE_COUNT = 2'd1,
      CSR_EXPIRY_COUNT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_LOG  = 2'd0,
      OP_SQRT = 2'd1,
      OP_DIV  = 2'd2
   } iter_op_type;

   // Command to the shared iterative unit.
   typedef struct packed {
      logic                       start;
      iter_op_type                op;
      logic [VALUE_W-1:0]         raw;
      logic signed [COORD_W-1:0]  num;
      logic signed [COORD_W-1:0]  den;
   } iter_cmd_type;

   // Reply from the shared iterative unit.
   typedef struct packed {
      logic                       done;
      logic signed [COORD_W-1:0]  result;
   } iter_rsp_type;

endpackage

`default_nettype wire

/* hdl/vsbi_if.sv */
// Handshake channel interfaces of the volatility surface lookup.
`default_nettype none

interface vsbi_req_if;
   import vsbi_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [1:0]             action;
   logic [3:0]             row_index;
   logic [3:0]             col_index;
   logic [VALUE_W-1:0]     node_value;
   logic [VALUE_W-1:0]     query_strike;
   logic [VALUE_W-1:0]     query_expiry;

   modport source (output valid, action, row_index, col_index, node_value,
                   query_strike, query_expiry, input ready);
   modport sink   (input valid, action, row_index, col_index, node_value,
                   query_strike, query_expiry, output ready);
endinterface

interface vsbi_rsp_if;
   import vsbi_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [VALUE_W-1:0]     vol;
   logic                   grid_empty;

   modport source (output valid, vol, grid_empty, input ready);
   modport sink   (input valid, vol, grid_empty, output ready);
endinterface

interface vsbi_csr_if;
   import vsbi_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [VALUE_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hdl/vsbi_iter_unit.sv */
// Shared iterative unit: fixed-point log2, square root and fraction divide.
`default_nettype none

module vsbi_iter_unit import vsbi_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  iter_cmd_type cmd,
   output iter_rsp_type rsp
);

   typedef enum logic [4:0] {
      IT_IDLE   = 5'b00001,
      IT_NORM   = 5'b00010,
      IT_SQUARE = 5'b00100,
      IT_ROOT   = 5'b01000,
      IT_DIVIDE = 5'b10000
   } it_state_type;

   it_state_type              state_ff, state_in;
   logic [4:0]                cnt_ff, cnt_in;
   logic [63:0]               x_ff, x_in;
   logic [35:0]               r_ff, r_in;
   logic [31:0]               q_ff, q_in;
   logic [4:0]                e_ff, e_in;
   logic                      done_ff, done_in;
   logic signed [COORD_W-1:0] res_ff, res_in;

   logic [5:0]  amt;
   logic [63:0] sq;
   logic [32:0] sq_top;
   logic [35:0] root_rem;
   logic [35:0] root_trial;
   logic [35:0] div_rem;
   logic [35:0] div_den;
   logic [5:0]  log_exp;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      r_in     = r_ff;
      q_in     = q_ff;
      e_in     = e_ff;
      done_in  = 1'b0;
      res_in   = res_ff;

      amt        = 6'd16 >> cnt_ff[2:0];
      sq         = x_ff[31:0] * x_ff[31:0];
      sq_top     = sq[63:31];
      root_rem   = {r_ff[33:0], x_ff[63:62]};
      root_trial = {2'b00, q_ff, 2'b01};
      div_rem    = {r_ff[34:0], 1'b0};
      div_den    = x_ff[35:0];
      log_exp    = {1'b0, e_ff} - 6'd16;

      case (state_ff)
         IT_IDLE: begin
            if (cmd.start) begin
               q_in = '0;
               r_in = '0;
               case (cmd.op)
                  OP_LOG: begin
                     // A zero argument is taken as the smallest raw value.
                     x_in     = {32'd0, (cmd.raw == '0) ? 32'd1 : cmd.raw};
                     e_in     = 5'd31;
                     cnt_in   = 5'd0;
                     state_in = IT_NORM;
                  end
                  OP_SQRT: begin
                     x_in     = {2'b00, cmd.raw, 30'd0};
                     cnt_in   = 5'd31;
                     state_in = IT_ROOT;
                  end
                  OP_DIV: begin
                     r_in     = 36'(unsigned'(cmd.num));
                     x_in     = 64'(unsigned'(cmd.den));
                     cnt_in   = 5'd15;
                     state_in = IT_DIVIDE;
                  end
                  default: state_in = IT_IDLE;
               endcase
            end
         end

         // Leading-one search in five halving steps.
         IT_NORM: begin
            if ((x_ff[31:0] >> (6'd32 - amt)) == 32'd0) begin
               x_in = {32'd0, x_ff[31:0] << amt};
               e_in = e_ff - amt[4:0];
            end
            if (cnt_ff == 5'd4) begin
               cnt_in   = 5'd23;
               state_in = IT_SQUARE;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end

         // One fraction bit per squaring of the mantissa.
         IT_SQUARE: begin
            if (sq_top[32]) begin
               x_in = {32'd0, sq_top[32:1]};
            end else begin
               x_in = {32'd0, sq_top[31:0]};
            end
            q_in = {q_ff[30:0], sq_top[32]};
            if (cnt_ff == 5'd0) begin
               res_in   = {{(COORD_W-FRAC_W-6){log_exp[5]}}, log_exp,
                           q_ff[FRAC_W-2:0], sq_top[32]};
               done_in  = 1'b1;
               state_in = IT_IDLE;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end

         // Restoring square root, one result bit per cycle.
         IT_ROOT: begin
            x_in = {x_ff[61:0], 2'b00};
            if (root_rem >= root_trial) begin
               r_in = root_rem - root_trial;
               q_in = {q_ff[30:0], 1'b1};
            end else begin
               r_in = root_rem;
               q_in = {q_ff[30:0], 1'b0};
            end
            if (cnt_ff == 5'd0) begin
               res_in   = COORD_W'(q_in);
               done_in  = 1'b1;
               state_in = IT_IDLE;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end

         // Restoring divide of a proper fraction into sixteen bits.
         IT_DIVIDE: begin
            if (div_rem >= div_den) begin
               r_in = div_rem - div_den;
               q_in = {q_ff[30:0], 1'b1};
            end else begin
               r_in = div_rem;
               q_in = {q_ff[30:0], 1'b0};
            end
            if (cnt_ff == 5'd0) begin
               res_in   = COORD_W'(q_in[15:0]);
               done_in  = 1'b1;
               state_in = IT_IDLE;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end

         default: state_in = IT_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IT_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      r_ff   <= r_in;
      q_ff   <= q_in;
      e_ff   <= e_in;
      res_ff <= res_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

endmodule

`default_nettype wire

/* hdl/vol_surface_bilinear_interp.sv */
// Top level of the volatility surface lookup: sequencer, node store, grid and blend.
//
//   channel  direction  handshake           word
//   req_ch   in         valid/ready         action, indexes, node value, query
//   rsp_ch   out        valid/ready         vol, grid_empty
//   csr_ch   in         valid/ready (=1)    register index, data
//
// A vol entry write goes straight to the grid; a strike node write runs the log
// unit and an expiry node write the root unit. A query runs one log, one root
// and up to two divides on the one shared iterative unit, steps over nodes in
// the two lower-bound searches and ends with the four-read blend; an empty grid
// answers without any of these.
// Synchronous reset clears the sequencer, counts and result valid flag; the
// node and grid stores hold nothing until written. A stalled result is held
// in its register while the block takes the next item.
`default_nettype none

module vol_surface_bilinear_interp import vsbi_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   vsbi_req_if.sink         req_ch,
   vsbi_rsp_if.source       rsp_ch,
   vsbi_csr_if.sink         csr_ch
);

   typedef enum logic [17:0] {
      ST_IDLE  = 18'd1,
      ST_NODE  = 18'd2,
      ST_QLOG  = 18'd4,
      ST_QSQRT = 18'd8,
      ST_LO    = 18'd16,
      ST_HI    = 18'd32,
      ST_SCAN  = 18'd64,
      ST_CELL0 = 18'd128,
      ST_CELL1 = 18'd256,
      ST_DIV   = 18'd512,
      ST_RD00  = 18'd1024,
      ST_RD01  = 18'd2048,
      ST_RD10  = 18'd4096,
      ST_RD11  = 18'd8192,
      ST_MB    = 18'd16384,
      ST_S0    = 18'd32768,
      ST_S1    = 18'd65536,
      ST_OUT   = 18'd131072
   } state_type;

   state_type                 state_ff, state_in;
   logic [COUNT_W-1:0]        strike_count_ff, expiry_count_ff;
   logic                      ax_ff, ax_in;
   logic [3:0]                widx_ff, widx_in;
   logic [VALUE_W-1:0]        qexp_ff, qexp_in;
   logic signed [COORD_W-1:0] q_ff, q_in;
   logic signed [COORD_W-1:0] qt_ff, qt_in;
   logic signed [COORD_W-1:0] c0_ff, c0_in;
   logic                      clo_ff, clo_in;
   logic [COUNT_W-1:0]        lb_ff, lb_in;
   logic [3:0]                i_ff, i_in;
   logic [K_IDX_W-1:0]        k0_ff, k0_in, k1_ff, k1_in;
   logic [T_IDX_W-1:0]        t0_ff, t0_in, t1_ff, t1_in;
   logic [WGT_W-1:0]          wk_ff, wk_in, wt_ff, wt_in;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic [ROW_W-1:0]          a_ff, a_in, b_ff, b_in;
   logic                      empty_ff, empty_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]        rsp_vol_ff, rsp_vol_in;
   logic                      rsp_empty_ff, rsp_empty_in;

   // Node coordinates, computed when a node is written.
   logic signed [COORD_W-1:0] kcoord_ff [MAX_STRIKES];
   logic signed [COORD_W-1:0] tcoord_ff [MAX_EXPIRIES];

   // Vol grid memory, row by expiry.
   logic [VALUE_W-1:0]        vol_mem [GRID_DEPTH];
   logic [VALUE_W-1:0]        rdata_ff;
   logic [GRID_ADDR_W-1:0]    raddr;

   iter_cmd_type              iter_cmd;
   iter_rsp_type              iter_rsp;

   logic                      req_accept;
   logic                      grid_we;
   logic [COUNT_W-1:0]        ns, ne, n_cur, lbm1, nm2, i_sel;
   logic [3:0]                rd_idx;
   logic signed [COORD_W-1:0] g_rd, num, den;
   logic                      commit;
   logic [3:0]                cm_i0, cm_i1;
   logic [WGT_W-1:0]          cm_w;
   logic [ROW_W-1:0]          mul_x;
   logic [WGT_W-1:0]          mul_y;
   logic [ROW_W+WGT_W-1:0]    prod;
   logic [ACC_W-1:0]          rounded;
   logic                      out_load;

   vsbi_iter_unit u_iter (
      .clock (clock),
      .reset (reset),
      .cmd   (iter_cmd),
      .rsp   (iter_rsp)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // Node counts above the store size are taken as the store size.
   assign ns = (strike_count_ff > COUNT_W'(MAX_STRIKES)) ? COUNT_W'(MAX_STRIKES)
                                                         : strike_count_ff;
   assign ne = (expiry_count_ff > COUNT_W'(MAX_EXPIRIES)) ? COUNT_W'(MAX_EXPIRIES)
                                                          : expiry_count_ff;
   assign n_cur = ax_ff ? ne : ns;

   // Single read port on the coordinate store of the axis being located.
   always_comb begin
      case (state_ff)
         ST_HI:    rd_idx = 4'(n_cur - 5'd1);
         ST_SCAN:  rd_idx = lb_ff[3:0];
         ST_CELL0: rd_idx = i_ff;
         ST_CELL1: rd_idx = i_ff + 4'd1;
         default:  rd_idx = 4'd0;
      endcase
   end
   assign g_rd = ax_ff ? tcoord_ff[rd_idx] : kcoord_ff[rd_idx];
   assign num  = q_ff - c0_ff;
   assign den  = g_rd - c0_ff;

   // Lower cell index from the scan position, kept within the grid.
   assign lbm1  = (lb_ff == '0) ? '0 : lb_ff - 5'd1;
   assign nm2   = n_cur - 5'd2;
   assign i_sel = (lbm1 > nm2) ? nm2 : lbm1;

   // Blend multiplier operands.
   always_comb begin
      case (state_ff)
         ST_RD01, ST_RD11: begin
            mul_x = ROW_W'(rdata_ff);
            mul_y = WONE - wk_ff;
         end
         ST_RD10, ST_MB: begin
            mul_x = ROW_W'(rdata_ff);
            mul_y = wk_ff;
         end
         ST_S0: begin
            mul_x = a_ff;
            mul_y = WONE - wt_ff;
         end
         ST_S1: begin
            mul_x = b_ff;
            mul_y = wt_ff;
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end
   assign prod    = mul_x * mul_y;
   assign rounded = acc_ff + 64'h0000_0000_8000_0000;

   // Grid address of each corner.
   always_comb begin
      case (state_ff)
         ST_RD00: raddr = {t0_ff, k0_ff};
         ST_RD01: raddr = {t0_ff, k1_ff};
         ST_RD10: raddr = {t1_ff, k0_ff};
         ST_RD11: raddr = {t1_ff, k1_ff};
         default: raddr = '0;
      endcase
   end

   // Main sequencer.
   always_comb begin
      state_in = state_ff;
      ax_in    = ax_ff;
      widx_in  = widx_ff;
      qexp_in  = qexp_ff;
      q_in     = q_ff;
      qt_in    = qt_ff;
      c0_in    = c0_ff;
      clo_in   = clo_ff;
      lb_in    = lb_ff;
      i_in     = i_ff;
      k0_in    = k0_ff;
      k1_in    = k1_ff;
      t0_in    = t0_ff;
      t1_in    = t1_ff;
      wk_in    = wk_ff;
      wt_in    = wt_ff;
      acc_in   = acc_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      empty_in = empty_ff;
      grid_we  = 1'b0;
      out_load = 1'b0;
      commit   = 1'b0;
      cm_i0    = 4'd0;
      cm_i1    = 4'd0;
      cm_w     = '0;
      iter_cmd = '{start: 1'b0, op: OP_LOG, raw: '0, num: num, den: den};

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (action_type'(req_ch.action))
                  ACT_STRIKE: begin
                     iter_cmd.start = 1'b1;
                     iter_cmd.op    = OP_LOG;
                     iter_cmd.raw   = req_ch.node_value;
                     ax_in          = 1'b0;
                     widx_in        = req_ch.col_index;
                     state_in       = ST_NODE;
                  end
                  ACT_EXPIRY: begin
                     iter_cmd.start = 1'b1;
                     iter_cmd.op    = OP_SQRT;
                     iter_cmd.raw   = req_ch.node_value;
                     ax_in          = 1'b1;
                     widx_in        = req_ch.row_index;
                     state_in       = ST_NODE;
                  end
                  ACT_VOL: begin
                     grid_we = 1'b1;
                  end
                  ACT_QUERY: begin
                     if (ns == '0 || ne == '0) begin
                        empty_in = 1'b1;
                        state_in = ST_OUT;
                     end else begin
                        empty_in       = 1'b0;
                        iter_cmd.start = 1'b1;
                        iter_cmd.op    = OP_LOG;
                        iter_cmd.raw   = req_ch.query_strike;
                        qexp_in        = req_ch.query_expiry;
                        state_in       = ST_QLOG;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         ST_NODE: begin
            if (iter_rsp.done) begin
               state_in = ST_IDLE;
            end
         end

         // The spot offset is common to every strike coordinate and cancels in
         // the clamp, the search and the weight, so it is left out.
         ST_QLOG: begin
            if (iter_rsp.done) begin
               q_in           = iter_rsp.result;
               iter_cmd.start = 1'b1;
               iter_cmd.op    = OP_SQRT;
               iter_cmd.raw   = qexp_ff;
               state_in       = ST_QSQRT;
            end
         end

         ST_QSQRT: begin
            if (iter_rsp.done) begin
               qt_in    = iter_rsp.result;
               ax_in    = 1'b0;
               state_in = ST_LO;
            end
         end

         // Clamp below the first node.
         ST_LO: begin
            clo_in = 1'b0;
            if (q_ff < g_rd) begin
               q_in   = g_rd;
               clo_in = 1'b1;
            end
            state_in = ST_HI;
         end

         // Otherwise clamp above the last node; a single node fixes the axis.
         ST_HI: begin
            if (!clo_ff && q_ff > g_rd) begin
               q_in = g_rd;
            end
            if (n_cur == 5'd1) begin
               commit = 1'b1;
            end else begin
               lb_in    = '0;
               state_in = ST_SCAN;
            end
         end

         // Lower bound: first node not below the query.
         ST_SCAN: begin
            if (lb_ff < n_cur && g_rd < q_ff) begin
               lb_in = lb_ff + 5'd1;
            end else begin
               i_in     = i_sel[3:0];
               state_in = ST_CELL0;
            end
         end

         ST_CELL0: begin
            c0_in    = g_rd;
            state_in = ST_CELL1;
         end

         // Weight: zero for an empty or negative cell or a query at or below its bottom, one at or past its top.
         ST_CELL1: begin
            cm_i0 = i_ff;
            cm_i1 = i_ff + 4'd1;
            if (den <= 0 || num <= 0) begin
               commit = 1'b1;
            end else if (num >= den) begin
               cm_w   = WONE;
               commit = 1'b1;
            end else begin
               iter_cmd.start = 1'b1;
               iter_cmd.op    = OP_DIV;
               state_in       = ST_DIV;
            end
         end

         ST_DIV: begin
            cm_i0 = i_ff;
            cm_i1 = i_ff + 4'd1;
            if (iter_rsp.done) begin
               cm_w   = WGT_W'(iter_rsp.result[15:0]);
               commit = 1'b1;
            end
         end

         ST_RD00: state_in = ST_RD01;

         ST_RD01: begin
            acc_in   = ACC_W'(prod);
            state_in = ST_RD10;
         end

         ST_RD10: begin
            acc_in   = acc_ff + ACC_W'(prod);
            state_in = ST_RD11;
         end

         ST_RD11: begin
            a_in     = acc_ff[ROW_W-1:0];
            acc_in   = ACC_W'(prod);
            state_in = ST_MB;
         end

         ST_MB: begin
            acc_in   = acc_ff + ACC_W'(prod);
            state_in = ST_S0;
         end

         ST_S0: begin
            b_in     = acc_ff[ROW_W-1:0];
            acc_in   = ACC_W'(prod);
            state_in = ST_S1;
         end

         ST_S1: begin
            acc_in   = acc_ff + ACC_W'(prod);
            state_in = ST_OUT;
         end

         // Wait for the result register to be free.
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // Close one axis: strike goes on to expiry, expiry goes on to the blend.
      if (commit) begin
         if (!ax_ff) begin
            k0_in    = K_IDX_W'(cm_i0);
            k1_in    = K_IDX_W'(cm_i1);
            wk_in    = cm_w;
            ax_in    = 1'b1;
            q_in     = qt_ff;
            state_in = ST_LO;
         end else begin
            t0_in    = T_IDX_W'(cm_i0);
            t1_in    = T_IDX_W'(cm_i1);
            wt_in    = cm_w;
            state_in = ST_RD00;
         end
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_vol_in   = rsp_vol_ff;
      rsp_empty_in = rsp_empty_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_vol_in   = empty_ff ? '0 : rounded[63:32];
         rsp_empty_in = empty_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         strike_count_ff <= '0;
         expiry_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_index_type'(csr_ch.index))
               CSR_STRIKE_COUNT: strike_count_ff <= csr_ch.data[COUNT_W-1:0];
               CSR_EXPIRY_COUNT: expiry_count_ff <= csr_ch.data[COUNT_W-1:0];
               default: ;
            endcase
         end
      end
      ax_ff        <= ax_in;
      widx_ff      <= widx_in;
      qexp_ff      <= qexp_in;
      q_ff         <= q_in;
      qt_ff        <= qt_in;
      c0_ff        <= c0_in;
      clo_ff       <= clo_in;
      lb_ff        <= lb_in;
      i_ff         <= i_in;
      k0_ff        <= k0_in;
      k1_ff        <= k1_in;
      t0_ff        <= t0_in;
      t1_ff        <= t1_in;
      wk_ff        <= wk_in;
      wt_ff        <= wt_in;
      acc_ff       <= acc_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      empty_ff     <= empty_in;
      rsp_vol_ff   <= rsp_vol_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   // Coordinate store writes when a node conversion completes.
   always_ff @(posedge clock) begin
      if (state_ff == ST_NODE && iter_rsp.done) begin
         if (ax_ff) begin
            tcoord_ff[widx_ff[T_IDX_W-1:0]] <= iter_rsp.result;
         end else begin
            kcoord_ff[widx_ff[K_IDX_W-1:0]] <= iter_rsp.result;
         end
      end
   end

   // Grid memory: one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (grid_we) begin
         vol_mem[{req_ch.row_index[T_IDX_W-1:0], req_ch.col_index[K_IDX_W-1:0]}]
            <= req_ch.node_value;
      end
      rdata_ff <= vol_mem[raddr];
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.vol        = rsp_vol_ff;
   assign rsp_ch.grid_empty = rsp_empty_ff;

`ifndef SYNTH
   // An empty grid always reports zero vol.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.grid_empty |-> rsp_ch.vol == '0)
      else $error("empty grid result carries a nonzero vol");

   // Both weights lie within [0, 1] when the blend starts.
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD00 |-> wk_ff <= WONE && wt_ff <= WONE)
      else $error("interpolation weight above one");

   // The shared unit only completes while the sequencer waits for it.
   a_iter_owner: assert property (@(posedge clock) disable iff (reset)
      iter_rsp.done |-> state_ff == ST_NODE || state_ff == ST_QLOG ||
                        state_ff == ST_QSQRT || state_ff == ST_DIV)
      else $error("iterative unit finished with nobody waiting");

   // Corner indexes stay inside the nodes in use.
   a_corner_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD00 |-> COUNT_W'(k1_ff) < ns && COUNT_W'(t1_ff) < ne)
      else $error("corner index beyond node count");
`endif

endmodule

`default_nettype wire
